// File: src/pipc_pkg.sv
// shared constants and types for the point-in-polygon crossing block
`timescale 1ns / 1ps

package pipc_pkg;

    // fixed point format: signed 16.16
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned FRAC_BITS = 16;

    // divider: dividend magnitude is the 32-bit numerator shifted up by the fraction
    localparam int unsigned DIVIDEND_W = WORD_W + FRAC_BITS;
    localparam int unsigned DIV_STEPS  = DIVIDEND_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

    // stream widths
    localparam int unsigned S_DATA_W = 6 * WORD_W;
    localparam int unsigned M_DATA_W = 8;

    // divider status back to the sequencer
    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quot;
    } div_res_t;

endpackage

// File: src/pipc_div.sv
// iterative restoring divider, one quotient bit per cycle, signed truncating result
`timescale 1ns / 1ps

module pipc_div
    import pipc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [WORD_W-1:0] dividend,
    input  logic signed [WORD_W-1:0] divisor,
    output div_res_t                 res
);

    logic                  busy_reg,   busy_next;
    logic                  done_reg,   done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg,    cnt_next;
    logic                  neg_reg,    neg_next;
    logic [DIVIDEND_W-1:0] num_reg,    num_next;
    logic [WORD_W-1:0]     dmag_reg,   dmag_next;
    logic [WORD_W-1:0]     rem_reg,    rem_next;
    logic [WORD_W-1:0]     quot_reg,   quot_next;

    logic [WORD_W-1:0]     nmag;
    logic [WORD_W-1:0]     dmag;
    logic [WORD_W:0]       trial;
    logic [WORD_W+1:0]     diff;
    logic                  ge;

    // operand magnitudes
    assign nmag = dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
    assign dmag = divisor[WORD_W-1]  ? (~divisor + 1'b1)  : divisor;

    // one shift-subtract step
    assign trial = {rem_reg, num_reg[DIVIDEND_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dmag_reg};
    assign ge    = ~diff[WORD_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        num_next  = num_reg;
        dmag_next = dmag_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
            num_next  = {nmag, {FRAC_BITS{1'b0}}};
            dmag_next = dmag;
            rem_next  = '0;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
            quot_next = {quot_reg[WORD_W-2:0], ge};
            num_next  = {num_reg[DIVIDEND_W-2:0], 1'b0};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        num_reg  <= num_next;
        dmag_reg <= dmag_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    // quotient low word, sign applied, wraps to 32 bits
    assign res.done = done_reg;
    assign res.quot = neg_reg ? (~quot_reg + 1'b1) : quot_reg;

endmodule

// File: src/point_in_polygon_crossing.sv
// Even-odd ray crossing test: one polygon edge per item, inside flag on the last edge.
// A straddling edge passes through prep, multiply, divider load, 48 divider steps, done, sum
// and finish after its accept; any other edge passes through prep, multiply and finish only.
// A new edge is accepted only once the sequencer is back in idle after the previous one.
// The result sits in an output register; a last edge waits only if it is still untaken.
// Reset (rst_n low, asynchronous) clears the parity, the sequencer and the output valid.
`timescale 1ns / 1ps

module point_in_polygon_crossing
    import pipc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // edge_x0, edge_z0, edge_x1, edge_z1, point_x, point_z
    input  logic                s_tlast,  // last_edge
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // inside_res, zero fill
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_START,
        S_DIV,
        S_SUM,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   parity_reg, parity_next;
    logic   m_valid_reg, m_valid_next;
    logic   inside_reg, inside_next;

    // captured item
    logic signed [WORD_W-1:0] x0_reg, z0_reg, x1_reg, z1_reg, px_reg, pz_reg;
    logic                     last_reg;

    // working registers
    logic signed [WORD_W-1:0]   a_reg, b_reg, d_reg, num_reg, q_reg;
    logic                       straddle_reg;
    logic signed [2*WORD_W-1:0] prod;
    logic signed [WORD_W-1:0]   cx;
    logic                       accept;
    logic                       div_start;
    div_res_t                   div_res;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign div_start = (state_reg == S_START);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(M_DATA_W-1){1'b0}}, inside_reg};

    // divider, started only for straddling edges
    pipc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (d_reg),
        .res      (div_res)
    );

    // product of the two differences, then crossing x
    assign prod = a_reg * b_reg;
    assign cx   = x0_reg + q_reg;

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        parity_next  = parity_reg;
        m_valid_next = m_valid_reg;
        inside_next  = inside_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = straddle_reg ? S_START : S_DONE;
            end
            S_START:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (px_reg < cx)
                begin
                    parity_next = ~parity_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    inside_next  = parity_reg;
                    parity_next  = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            parity_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            inside_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            parity_reg  <= parity_next;
            m_valid_reg <= m_valid_next;
            inside_reg  <= inside_next;
        end
    end

    // item capture and datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x0_reg   <= s_tdata[0*WORD_W +: WORD_W];
            z0_reg   <= s_tdata[1*WORD_W +: WORD_W];
            x1_reg   <= s_tdata[2*WORD_W +: WORD_W];
            z1_reg   <= s_tdata[3*WORD_W +: WORD_W];
            px_reg   <= s_tdata[4*WORD_W +: WORD_W];
            pz_reg   <= s_tdata[5*WORD_W +: WORD_W];
            last_reg <= s_tlast;
        end
        // differences wrap to 32 bits, half-open straddle test on z
        if (state_reg == S_PREP)
        begin
            a_reg        <= pz_reg - z0_reg;
            b_reg        <= x1_reg - x0_reg;
            d_reg        <= z1_reg - z0_reg;
            straddle_reg <= ((z0_reg <= pz_reg) && (z1_reg > pz_reg))
                         || ((z1_reg <= pz_reg) && (z0_reg > pz_reg));
        end
        // floor shift by the fraction, wrapped to 32 bits
        if (state_reg == S_MUL)
        begin
            num_reg <= prod[FRAC_BITS +: WORD_W];
        end
        if (div_res.done)
        begin
            q_reg <= div_res.quot;
        end
    end

`ifndef SYNTH
    // a finished polygon loads the result and clears the parity
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && last_reg && (!m_valid_reg || m_tready))
        |=> (m_tvalid && !parity_reg))
        else $error("result not loaded or parity not cleared");

    // divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == S_DIV))
        else $error("divider done outside the divide phase");

    // an accepted item starts the sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_PREP))
        else $error("accepted item did not start processing");

    // parity changes only on a crossing update or on a finished polygon
    assert property (@(posedge clk) disable iff (!rst_n)
        (parity_reg != $past(parity_reg)) |->
            ($past(state_reg) == S_SUM || $past(state_reg) == S_DONE))
        else $error("parity changed outside an update");
`endif

endmodule
